// File: rtl/kwm_pkg.sv
// Shared item types and codes for the k-way merge engine.
package kwm_pkg;

    localparam int unsigned LIST_FIELD_BITS = 3;
    localparam int unsigned DATA_FIELD_BITS = 32;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                              action;
        logic [LIST_FIELD_BITS-1:0]        list_index;
        logic signed [DATA_FIELD_BITS-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                        status;
        logic signed [DATA_FIELD_BITS-1:0] merged_value;
        logic [LIST_FIELD_BITS-1:0]        source_list;
    } out_item_t;

endpackage

// File: rtl/kwm_min_select.sv
// Least-head selection over the cached list heads, lower index wins ties.
module kwm_min_select #(
    parameter int LISTS      = 8,
    parameter int VALUE_BITS = 32,
    parameter int LIST_BITS  = $clog2(LISTS)
) (
    input  logic [LISTS-1:0][VALUE_BITS-1:0] heads,
    input  logic [LISTS-1:0]                 nonempty,
    output logic                             found,
    output logic [LIST_BITS-1:0]             best_idx,
    output logic [VALUE_BITS-1:0]            best_val
);

    always_comb
    begin
        found    = 1'b0;
        best_idx = '0;
        best_val = '0;
        for (int i = 0; i < LISTS; i++)
        begin
            if (nonempty[i] && (!found || ($signed(heads[i]) < $signed(best_val))))
            begin
                found    = 1'b1;
                best_idx = LIST_BITS'(i);
                best_val = heads[i];
            end
        end
    end

endmodule

// File: rtl/k_way_merge_engine_core.sv
// Top level of the k-way merge engine: list queues in one store, cached heads.
// The result item is registered at the edge that accepts the item.
// A push, or a pop that leaves its list empty, frees the input again unless out_stall holds it; a
// pop that leaves entries behind also waits in S_FILL on the store read that refills the head.
// Reset clears every list to empty; store contents are left as they are.
module k_way_merge_engine_core #(
    parameter int LISTS      = 8,
    parameter int DEPTH      = 128,
    parameter int VALUE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  kwm_pkg::in_item_t in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output kwm_pkg::out_item_t out_item
);

    import kwm_pkg::*;

    localparam int LIST_BITS = $clog2(LISTS);
    localparam int IDX_W     = (LIST_BITS > LIST_FIELD_BITS) ? LIST_BITS : LIST_FIELD_BITS;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int ADDR_W    = $clog2(LISTS * DEPTH);
    localparam int WORDS     = LISTS * DEPTH;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [PTR_W-1:0]                 rd_reg   [LISTS];
    logic [CNT_W-1:0]                 cnt_reg  [LISTS];
    logic [LISTS-1:0][VALUE_BITS-1:0] head_reg;
    logic [LISTS-1:0]                 nonempty;
    logic [LIST_BITS-1:0]             fill_list_reg;
    logic                             out_valid_reg;
    out_item_t                        out_item_reg;
    out_item_t                        result;

    logic [VALUE_BITS-1:0] mem [WORDS];
    logic [VALUE_BITS-1:0] mem_rdata_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ADDR_W-1:0]     mem_raddr;

    logic                  accept;
    logic [IDX_W-1:0]      idx_wide;
    logic [LIST_BITS-1:0]  push_q;
    logic                  in_range;
    logic                  push_ok;
    logic                  pop_ok;
    logic                  pop_refill;
    logic [SUM_W-1:0]      tail_sum;
    logic [PTR_W-1:0]      tail_slot;
    logic [PTR_W-1:0]      rd_inc;
    logic [VALUE_BITS-1:0] value_ext;

    logic                  found;
    logic [LIST_BITS-1:0]  best_idx;
    logic [VALUE_BITS-1:0] best_val;

    always_comb
    begin
        for (int i = 0; i < LISTS; i++)
        begin
            nonempty[i] = (cnt_reg[i] != '0);
        end
    end

    kwm_min_select #(
        .LISTS      (LISTS),
        .VALUE_BITS (VALUE_BITS),
        .LIST_BITS  (LIST_BITS)
    ) u_min_select (
        .heads    (head_reg),
        .nonempty (nonempty),
        .found    (found),
        .best_idx (best_idx),
        .best_val (best_val)
    );

    assign in_stall = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;

    assign idx_wide  = IDX_W'(in_item.list_index);
    assign push_q    = idx_wide[LIST_BITS-1:0];
    assign in_range  = (32'(idx_wide) < LISTS);
    assign value_ext = VALUE_BITS'(in_item.value);

    always_comb
    begin
        push_ok    = (in_item.action == ACT_PUSH) && in_range &&
                     (cnt_reg[push_q] != CNT_W'(DEPTH));
        pop_ok     = (in_item.action == ACT_POP) && found;
        pop_refill = pop_ok && (cnt_reg[best_idx] != CNT_W'(1));

        tail_sum  = SUM_W'(rd_reg[push_q]) + SUM_W'(cnt_reg[push_q]);
        tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);
        rd_inc    = (rd_reg[best_idx] == PTR_W'(DEPTH - 1)) ? '0
                                                             : rd_reg[best_idx] + 1'b1;

        mem_we    = accept && push_ok;
        mem_waddr = ADDR_W'(ADDR_W'(push_q) * ADDR_W'(DEPTH)) + ADDR_W'(tail_slot);
        mem_raddr = ADDR_W'(ADDR_W'(best_idx) * ADDR_W'(DEPTH)) + ADDR_W'(rd_inc);

        result.status       = STATUS_OK;
        result.merged_value = '0;
        result.source_list  = '0;
        if (in_item.action == ACT_PUSH)
        begin
            if (!push_ok)
            begin
                result.status = STATUS_FULL;
            end
        end
        else if (found)
        begin
            result.merged_value = DATA_FIELD_BITS'($signed(best_val));
            result.source_list  = LIST_FIELD_BITS'(best_idx);
        end
        else
        begin
            result.status = STATUS_EMPTY;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && pop_refill)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= value_ext;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LISTS; i++)
            begin
                rd_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && push_ok)
            begin
                cnt_reg[push_q] <= cnt_reg[push_q] + 1'b1;
            end
            if (accept && pop_ok)
            begin
                rd_reg[best_idx]  <= rd_inc;
                cnt_reg[best_idx] <= cnt_reg[best_idx] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= result;
            if (push_ok && (cnt_reg[push_q] == '0))
            begin
                head_reg[push_q] <= value_ext;
            end
            if (pop_refill)
            begin
                fill_list_reg <= best_idx;
            end
        end
        if (state_reg == S_FILL)
        begin
            head_reg[fill_list_reg] <= mem_rdata_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: dv/tb_top.sv
// Testbench for the k-way merge engine: directed table, list fill and wrap, random merge runs.
`timescale 1ns / 1ps

module tb_top;
    import kwm_pkg::*;

    localparam int LISTS       = 8;
    localparam int DEPTH       = 128;
    localparam int RAND_ITEMS  = 1000;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DIR_ROWS    = 23;

    typedef struct packed {
        in_item_t  stim;
        out_item_t want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_EMPTY, 32'h00000000, 3'd0}},
        '{'{ACT_PUSH, 3'd0, 32'h7FFFFFFF}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_PUSH, 3'd7, 32'h80000000}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_PUSH, 3'd3, 32'h00000000}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_PUSH, 3'd3, 32'hFFFFFFFF}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_OK,    32'h80000000, 3'd7}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_OK,    32'h00000000, 3'd3}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_OK,    32'hFFFFFFFF, 3'd3}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_OK,    32'h7FFFFFFF, 3'd0}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_EMPTY, 32'h00000000, 3'd0}},
        // equal heads leave in list order
        '{'{ACT_PUSH, 3'd5, 32'h0000002A}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_PUSH, 3'd2, 32'h0000002A}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_PUSH, 3'd6, 32'h0000002A}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_OK,    32'h0000002A, 3'd2}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_OK,    32'h0000002A, 3'd5}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_OK,    32'h0000002A, 3'd6}},
        // pop ignores list index and value
        '{'{ACT_PUSH, 3'd1, 32'h55555555}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_PUSH, 3'd4, 32'hAAAAAAAA}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_PUSH, 3'd6, 32'h00000001}, '{STATUS_OK,    32'h00000000, 3'd0}},
        '{'{ACT_POP,  3'd7, 32'hFFFFFFFF}, '{STATUS_OK,    32'hAAAAAAAA, 3'd4}},
        '{'{ACT_POP,  3'd2, 32'h12345678}, '{STATUS_OK,    32'h00000001, 3'd6}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_OK,    32'h55555555, 3'd1}},
        '{'{ACT_POP,  3'd0, 32'h00000000}, '{STATUS_EMPTY, 32'h00000000, 3'd0}}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    logic signed [31:0] lane_mem  [LISTS][DEPTH];
    int                 lane_head [LISTS];
    int                 lane_fill [LISTS];

    out_item_t due_results[$];
    out_item_t pinned_results[$];
    int        mismatch_cnt = 0;
    int        cycle_cnt    = 0;
    bit        calm         = 1'b0;
    bit        hold_req     = 1'b0;

    k_way_merge_engine_core #(
        .LISTS     (LISTS),
        .DEPTH     (DEPTH),
        .VALUE_BITS(32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    always #1 clk = ~clk;

    initial
    begin
        for (int q = 0; q < LISTS; q++)
        begin
            lane_head[q] = 0;
            lane_fill[q] = 0;
        end
    end

    function automatic out_item_t merge_predict(input in_item_t it);
        out_item_t          r;
        int                 li;
        int                 best;
        int                 slot;
        logic signed [31:0] best_val;
        r        = '0;
        li       = int'(it.list_index);
        best     = -1;
        best_val = '0;
        if (it.action == ACT_PUSH)
        begin
            if (li >= LISTS || lane_fill[li] >= DEPTH)
                r.status = STATUS_FULL;
            else
            begin
                slot = (lane_head[li] + lane_fill[li]) % DEPTH;
                lane_mem[li][slot] = it.value;
                lane_fill[li]++;
            end
        end
        else
        begin
            for (int q = 0; q < LISTS; q++)
                if (lane_fill[q] != 0 && (best < 0 || lane_mem[q][lane_head[q]] < best_val))
                begin
                    best     = q;
                    best_val = lane_mem[q][lane_head[q]];
                end
            if (best < 0)
                r.status = STATUS_EMPTY;
            else
            begin
                r.merged_value  = best_val;
                r.source_list   = best[LIST_FIELD_BITS-1:0];
                lane_head[best] = (lane_head[best] + 1) % DEPTH;
                lane_fill[best]--;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_cnt < 100)
            $display("[%0d] mismatch: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    task automatic send_item(input in_item_t it);
        int gap;
        in_item  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            want = merge_predict(in_item);
            if (pinned_results.size() != 0)
                want = pinned_results.pop_front();
            due_results.push_back(want);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
                note_mismatch("result item with nothing expected");
            else
            begin
                want = due_results.pop_front();
                if (out_item.status != want.status)
                    note_mismatch($sformatf("status %0d, expected %0d",
                                            out_item.status, want.status));
                if (out_item.merged_value != want.merged_value)
                    note_mismatch($sformatf("merged_value %0d, expected %0d",
                                            out_item.merged_value, want.merged_value));
                if (out_item.source_list != want.source_list)
                    note_mismatch($sformatf("source_list %0d, expected %0d",
                                            out_item.source_list, want.source_list));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold on request
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (int hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        in_item_t it;
        longint   run_val [LISTS];
        int       rand_sent;
        int       round;
        int       npush;
        int       bias;
        int       li;
        logic [LISTS-1:0] mask;

        rand_sent = 0;
        round     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            pinned_results.push_back(DIRECTED[i].want);
            send_item(DIRECTED[i].stim);
        end

        // fill one list, overflow it, wrap its ring, then drain everything
        it = '0;
        it.action     = ACT_PUSH;
        it.list_index = 3'd5;
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            it.value = 32'(i * 3 - 200);
            send_item(it);
        end
        it.list_index = 3'd0;
        it.value      = 32'(-150);
        send_item(it);
        it.action = ACT_POP;
        for (int i = 0; i < DEPTH / 2; i++)
            send_item(it);
        it.action     = ACT_PUSH;
        it.list_index = 3'd5;
        for (int i = 0; i < DEPTH / 2 + 1; i++)
        begin
            it.value = 32'(400 + i);
            send_item(it);
        end
        it.action = ACT_POP;
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(it);
        drain_results();

        while (rand_sent < RAND_ITEMS)
        begin
            round++;
            calm = ($urandom_range(0, 4) == 0);
            if (round == 3)
                hold_req = 1'b1;
            if (round == 6 || round % 15 == 0)
                drain_results();
            if ($urandom_range(0, 9) < 7)
            begin
                // sorted runs into a subset of lists, then merge them out
                mask = LISTS'($urandom_range(1, (1 << LISTS) - 1));
                for (int q = 0; q < LISTS; q++)
                    case ($urandom_range(0, 3))
                        0: run_val[q] = -64'sd2147483648;
                        1: run_val[q] = longint'($signed($urandom)) >>> 1;
                        2: run_val[q] = longint'($urandom_range(0, 16)) - 8;
                        default: run_val[q] = 64'sd2147483627;
                    endcase
                npush = $urandom_range(4, 40);
                for (int n = 0; n < npush; n++)
                begin
                    do
                        li = $urandom_range(0, LISTS - 1);
                    while (!mask[li]);
                    it.action     = ACT_PUSH;
                    it.list_index = LIST_FIELD_BITS'(li);
                    it.value      = (run_val[li] > 64'sd2147483647) ? 32'h7FFFFFFF
                                                                    : 32'(run_val[li]);
                    run_val[li]  += $urandom_range(0, 3);
                    send_item(it);
                end
                npush += $urandom_range(0, 2);
                for (int n = 0; n < npush; n++)
                begin
                    it.action     = ACT_POP;
                    it.list_index = LIST_FIELD_BITS'($urandom);
                    it.value      = $urandom;
                    send_item(it);
                end
                rand_sent += 2 * npush;
            end
            else
            begin
                npush = $urandom_range(10, 30);
                bias  = $urandom_range(20, 90);
                for (int n = 0; n < npush; n++)
                begin
                    it.action     = ($urandom_range(0, 99) < bias) ? ACT_PUSH : ACT_POP;
                    it.list_index = LIST_FIELD_BITS'($urandom);
                    it.value      = $urandom_range(0, 1) ? 32'($urandom)
                                                         : 32'($urandom_range(0, 8)) - 32'd4;
                    send_item(it);
                end
                rand_sent += npush;
            end
        end

        calm = 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
